// ===== design/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg: shared types and constants of the pitch set quantizer
// Mask geometry, the count tree layout, register indexes and the packed
// request and result items.
// ----------------------------------------------------------------------------
package psq_pkg;

  // Register and mask geometry
  localparam int unsigned RegW        = 64;
  localparam int unsigned NumRegs     = 4;
  localparam int unsigned RegAddrLsb  = 3;
  localparam int unsigned RegIdxW     = $clog2(NumRegs);
  localparam int unsigned AddrW       = RegIdxW + RegAddrLsb;
  localparam int unsigned MaskW       = 2 * RegW;
  localparam int unsigned NumPitches  = 128;
  localparam int unsigned PitchW      = $clog2(MaskW);
  localparam int unsigned CntW        = PitchW + 1;

  // Count tree: level k holds the allowed count of each aligned block of 2**k
  // pitches; levels TreeLo..PitchW are kept in registers
  localparam int unsigned TreeLo      = 2;
  localparam int unsigned TopNodes    = MaskW >> TreeLo;

  // Request and result items
  localparam int unsigned QueryW      = PitchW + 2;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 40;

  // Pitches that take part at all
  localparam logic [MaskW-1:0] PitchValid = {MaskW{1'b1}} >> (MaskW - NumPitches);

  typedef enum logic [RegIdxW-1:0] {
    RegAllowedLo = 2'd0,
    RegAllowedHi = 2'd1,
    RegScaleLo   = 2'd2,
    RegScaleHi   = 2'd3
  } reg_idx_e;

  typedef logic [PitchW:TreeLo][TopNodes-1:0][CntW-1:0] cnt_tree_t;

  typedef struct packed {
    logic [MaskW-1:0] allowed;
    logic [MaskW-1:0] in_scale;
    cnt_tree_t        cnt;
  } psq_cfg_t;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic [PitchW-1:0]        query_row;
    logic signed [QueryW-1:0] query_pitch;
  } psq_item_t;

  typedef struct packed {
    logic [CntW-1:0]   shown_count;
    logic              row_in_scale;
    logic              row_valid;
    logic [PitchW-1:0] row_pitch;
    logic              pitch_shown;
    logic [PitchW-1:0] pitch_row;
    logic              nearest_found;
    logic [PitchW-1:0] nearest_pitch;
  } psq_res_t;

endpackage

// ===== design/psq_regs.sv =====
// ----------------------------------------------------------------------------
// psq_regs: configuration registers and allowed-pitch count tree
// APB register file for the allowed and scale masks, plus a registered tree
// of block counts over the allowed mask that the query logic descends.
// ----------------------------------------------------------------------------
module psq_regs
  import psq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready,
  output psq_cfg_t         cfg_o
);

  // Build block counts level by level from single mask bits
  function automatic cnt_tree_t tree_counts(input logic [MaskW-1:0] m);
    logic [CntW-1:0] lvl [PitchW+1][MaskW];
    cnt_tree_t       t;
    lvl = '{default: '0};
    t   = '0;
    for (int unsigned i = 0; i < MaskW; i++) begin
      lvl[0][i] = CntW'(m[i]);
    end
    for (int unsigned k = 1; k <= PitchW; k++) begin
      for (int unsigned i = 0; i < (MaskW >> k); i++) begin
        lvl[k][i] = lvl[k-1][2*i] + lvl[k-1][2*i+1];
      end
    end
    for (int unsigned k = TreeLo; k <= PitchW; k++) begin
      for (int unsigned i = 0; i < (MaskW >> k); i++) begin
        t[k][i] = lvl[k][i];
      end
    end
    return t;
  endfunction

  logic [RegW-1:0]  allowed_lo_q, allowed_hi_q, scale_lo_q, scale_hi_q;
  logic [MaskW-1:0] allowed;
  cnt_tree_t        cnt_d, cnt_q;
  reg_idx_e         reg_idx;
  logic             wr_en;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:RegAddrLsb]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the addressed mask word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_lo_q <= '1;
      allowed_hi_q <= '1;
      scale_lo_q   <= '1;
      scale_hi_q   <= '1;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegAllowedLo: allowed_lo_q <= pwdata;
        RegAllowedHi: allowed_hi_q <= pwdata;
        RegScaleLo:   scale_lo_q   <= pwdata;
        RegScaleHi:   scale_hi_q   <= pwdata;
        default:      ;
      endcase
    end
  end

  // Return the addressed mask word
  always_comb begin
    unique case (reg_idx)
      RegAllowedLo: prdata = allowed_lo_q;
      RegAllowedHi: prdata = allowed_hi_q;
      RegScaleLo:   prdata = scale_lo_q;
      RegScaleHi:   prdata = scale_hi_q;
      default:      prdata = '0;
    endcase
  end

  assign allowed = {allowed_hi_q, allowed_lo_q} & PitchValid;
  assign cnt_d   = tree_counts(allowed);

  // Refresh the count tree; it is updated in the cycle after a mask write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= tree_counts(PitchValid);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cfg_o.allowed  = allowed;
  assign cfg_o.in_scale = {scale_hi_q, scale_lo_q} & PitchValid;
  assign cfg_o.cnt      = cnt_q;

endmodule

// ===== design/psq_core.sv =====
// ----------------------------------------------------------------------------
// psq_core: query logic of the pitch set quantizer
// Nearest allowed pitch by two priority encoders, row of the query pitch and
// pitch of the query row by walking the count tree from the root.
// ----------------------------------------------------------------------------
module psq_core
  import psq_pkg::*;
(
  input  psq_cfg_t  cfg_i,
  input  psq_item_t item_i,
  output psq_res_t  res_o
);

  localparam logic [PitchW-1:0] TopPitch = PitchW'(MaskW - 1);

  // Allowed count of one node of the tree; the two lowest levels come from
  // the mask bits directly
  function automatic logic [CntW-1:0] node_cnt(input psq_cfg_t cfg, input int unsigned lvl,
                                               input logic [PitchW-1:0] idx);
    logic [CntW-1:0] c;
    c = '0;
    priority if (lvl >= TreeLo) begin
      c = cfg.cnt[lvl][idx[$clog2(TopNodes)-1:0]];
    end else if (lvl == 1) begin
      c = CntW'(cfg.allowed[{idx[PitchW-2:0], 1'b1}]) +
          CntW'(cfg.allowed[{idx[PitchW-2:0], 1'b0}]);
    end else begin
      c = CntW'(cfg.allowed[idx]);
    end
    return c;
  endfunction

  // Highest set bit
  function automatic logic [PitchW-1:0] msb_index(input logic [MaskW-1:0] v);
    logic [PitchW-1:0] r;
    r = '0;
    for (int unsigned p = 0; p < MaskW; p++) begin
      if (v[p]) r = PitchW'(p);
    end
    return r;
  endfunction

  // Lowest set bit
  function automatic logic [PitchW-1:0] lsb_index(input logic [MaskW-1:0] v);
    logic [PitchW-1:0] r;
    r = '0;
    for (int unsigned p = MaskW; p > 0; p--) begin
      if (v[p-1]) r = PitchW'(p - 1);
    end
    return r;
  endfunction

  logic signed [QueryW-1:0] q;
  logic [PitchW-1:0]        q7;
  logic                     q_neg, q_big, shown;
  logic [MaskW-1:0]         le_mask, lo_set, hi_set;
  logic                     have_lo, have_hi;
  logic [PitchW-1:0]        lower, higher;
  logic [PitchW-1:0]        nearest;
  logic                     found;
  logic [PitchW-1:0]        row_idx, rank;
  logic [CntW-1:0]          above, c_hi, total;
  logic                     row_ok;

  assign q     = item_i.query_pitch;
  assign q7    = q[PitchW-1:0];
  assign q_neg = q[QueryW-1];
  assign q_big = !q[QueryW-1] && q[PitchW];
  assign total = cfg_i.cnt[PitchW][0];
  assign shown = !q_neg && !q_big && cfg_i.allowed[q7];

  // Split the allowed set at the query pitch
  always_comb begin
    priority if (q_neg) begin
      le_mask = '0;
    end else if (q_big) begin
      le_mask = '1;
    end else begin
      le_mask = {MaskW{1'b1}} >> (TopPitch - q7);
    end
  end

  assign lo_set  = cfg_i.allowed & le_mask;
  assign hi_set  = cfg_i.allowed & ~le_mask;
  assign have_lo = |lo_set;
  assign have_hi = |hi_set;
  assign lower   = msb_index(lo_set);
  assign higher  = lsb_index(hi_set);

  // Pick the nearest neighbor, lower one on a tie, clamp at the set ends
  always_comb begin
    found = 1'b1;
    priority if (!have_lo && !have_hi) begin
      found   = 1'b0;
      nearest = '0;
    end else if (!have_lo) begin
      nearest = higher;
    end else if (!have_hi) begin
      nearest = lower;
    end else if ((q7 - lower) <= (higher - q7)) begin
      nearest = lower;
    end else begin
      nearest = higher;
    end
  end

  // Count allowed pitches above the query: add the upper sibling at each
  // level where the query path turns low
  always_comb begin
    above = '0;
    for (int unsigned k = 1; k <= PitchW; k++) begin
      if (!q7[k-1]) begin
        above = above + node_cnt(cfg_i, k - 1, PitchW'((q7 >> k) << 1) | PitchW'(1));
      end
    end
  end

  // Walk down from the root toward the node of the requested rank
  always_comb begin
    rank    = item_i.query_row;
    row_idx = '0;
    c_hi    = '0;
    for (int unsigned k = PitchW; k >= 1; k--) begin
      c_hi = node_cnt(cfg_i, k - 1, {row_idx[PitchW-2:0], 1'b1});
      if ({1'b0, rank} < c_hi) begin
        row_idx = {row_idx[PitchW-2:0], 1'b1};
      end else begin
        rank    = rank - c_hi[PitchW-1:0];
        row_idx = {row_idx[PitchW-2:0], 1'b0};
      end
    end
  end

  assign row_ok = {1'b0, item_i.query_row} < total;

  assign res_o.nearest_pitch = nearest;
  assign res_o.nearest_found = found;
  assign res_o.pitch_shown   = shown;
  assign res_o.pitch_row     = shown ? above[PitchW-1:0] : '0;
  assign res_o.row_valid     = row_ok;
  assign res_o.row_pitch     = row_ok ? row_idx : '0;
  assign res_o.row_in_scale  = row_ok && cfg_i.in_scale[row_idx];
  assign res_o.shown_count   = total;

endmodule

// ===== design/pitch_set_quantizer.sv =====
// ----------------------------------------------------------------------------
// pitch_set_quantizer: quantize pitches against a configurable pitch set
// Pipeline: an accepted request is held in the input register; its result is
//   captured in the result register and offered from there.
// Throughput: one request per cycle unless the result stream stalls; the query
//   logic sits between the input register and the result register, and each stage holds while stalled.
// Reset: all pitches allowed and in scale (chromatic); count tree follows
//   a mask write in the cycle after it.
// ----------------------------------------------------------------------------
module pitch_set_quantizer
  import psq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [RegW-1:0]     pwdata,
  output logic [RegW-1:0]     prdata,
  output logic                pready,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // query_pitch[8:0], query_row[15:9]
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // nearest_pitch[6:0], nearest_found[7],
                                             // pitch_row[14:8], pitch_shown[15],
                                             // row_pitch[22:16], row_valid[23],
                                             // row_in_scale[24], shown_count[32:25]
);

  psq_cfg_t  cfg;
  psq_item_t s1_item_q;
  psq_res_t  res, m_res_q;
  logic      s1_valid_q, m_valid_q;
  logic      s1_adv, accept;

  psq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psq_core u_core (
    .cfg_i  (cfg),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  // Advance when the result register is free or being drained
  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= psq_item_t'(s_axis_tdata);
    end
  end

  // Result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= s1_valid_q;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(psq_res_t))'(0), m_res_q};

  // A stalled request holds in the input stage
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("input stage lost or changed a stalled request");

  // Nearest pitch is found exactly when the set is nonempty
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_res_q.nearest_found == (m_res_q.shown_count != '0)))
    else $error("nearest_found disagrees with shown_count");

  // A shown pitch ranks below the allowed count
  a_row_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_res_q.pitch_shown |->
      ({1'b0, m_res_q.pitch_row} < m_res_q.shown_count))
    else $error("pitch_row beyond allowed count");

  // Scale flag only on a valid row
  a_scale_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_res_q.row_in_scale |-> m_res_q.row_valid)
    else $error("row_in_scale set on an invalid row");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream check of the pitch set quantizer
// Walks a short table of directed requests and register writes, then random
// pitch sets and random requests under three idle patterns. Every result is
// compared field by field against a known answer from the table or against an
// in-bench quantizer that tracks the register writes.
// ----------------------------------------------------------------------------
module testbench
  import psq_pkg::*;
();

  localparam int CycleLimit   = 200000;
  localparam int ItemsPerSet  = 60;
  localparam int SetsPerMode  = 3;

  typedef enum logic [1:0] {
    StepWrite,
    StepQuery,
    StepKnown
  } step_kind_e;

  typedef struct {
    step_kind_e kind;
    reg_idx_e   idx;
    logic [63:0] value;
    int          pitch;
    int          row;
    psq_res_t    known;
  } stim_step_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [RegW-1:0]     pwdata        = '0;
  logic [RegW-1:0]     prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // query_pitch[8:0], query_row[15:9]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // nearest_pitch[6:0], nearest_found[7],
                                            // pitch_row[14:8], pitch_shown[15],
                                            // row_pitch[22:16], row_valid[23],
                                            // row_in_scale[24], shown_count[32:25]

  // Bench copy of the pitch sets
  logic [MaskW-1:0] allowed_set = '1;
  logic [MaskW-1:0] scale_set   = '1;

  psq_res_t   pending_answers[$];
  stim_step_t directed_steps[$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 6;
  int         recv_stall_pct = 77;

  pitch_set_quantizer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Quantize one request against the bench copy of the pitch sets
  function automatic psq_res_t quantize_query(input logic signed [8:0] qpitch,
                                              input logic [6:0] qrow);
    psq_res_t r;
    int       q;
    int       p;
    int       total;
    int       above;
    int       lower;
    int       higher;
    int       rpitch;
    int       nearest;
    bit       rvalid;
    bit       found;
    bit       shown;
    q       = qpitch;
    total   = 0;
    above   = 0;
    lower   = -1;
    higher  = -1;
    rpitch  = 0;
    nearest = 0;
    rvalid  = 1'b0;
    found   = 1'b1;
    // Walk from the highest pitch down, ranking allowed pitches
    for (p = NumPitches - 1; p >= 0; p--) begin
      if (!allowed_set[p]) continue;
      if (total == int'(qrow)) begin
        rpitch = p;
        rvalid = 1'b1;
      end
      total++;
      if (p > q) begin
        above++;
        higher = p;
      end else if (lower < 0) begin
        lower = p;
      end
    end
    // Nearest neighbor, ties to the lower pitch
    if (lower < 0 && higher < 0) begin
      found = 1'b0;
    end else if (lower < 0) begin
      nearest = higher;
    end else if (higher < 0) begin
      nearest = lower;
    end else begin
      nearest = (q - lower <= higher - q) ? lower : higher;
    end
    shown = 1'b0;
    if (q >= 0 && q < NumPitches) begin
      shown = allowed_set[q];
    end
    r               = '0;
    r.nearest_pitch = 7'(nearest);
    r.nearest_found = found;
    r.pitch_row     = shown ? 7'(above) : 7'd0;
    r.pitch_shown   = shown;
    r.row_pitch     = rvalid ? 7'(rpitch) : 7'd0;
    r.row_valid     = rvalid;
    r.row_in_scale  = rvalid && scale_set[rpitch];
    r.shown_count   = 8'(total);
    return r;
  endfunction

  function automatic psq_res_t res_of(input int nearest, input int found, input int prow,
                                      input int shown, input int rpitch, input int rvalid,
                                      input int rscale, input int total);
    psq_res_t r;
    r.nearest_pitch = 7'(nearest);
    r.nearest_found = 1'(found);
    r.pitch_row     = 7'(prow);
    r.pitch_shown   = 1'(shown);
    r.row_pitch     = 7'(rpitch);
    r.row_valid     = 1'(rvalid);
    r.row_in_scale  = 1'(rscale);
    r.shown_count   = 8'(total);
    return r;
  endfunction

  function automatic stim_step_t step_write(input reg_idx_e idx, input logic [63:0] value);
    stim_step_t s;
    s.kind  = StepWrite;
    s.idx   = idx;
    s.value = value;
    s.pitch = 0;
    s.row   = 0;
    s.known = '0;
    return s;
  endfunction

  function automatic stim_step_t step_query(input int pitch, input int row);
    stim_step_t s;
    s.kind  = StepQuery;
    s.idx   = RegAllowedLo;
    s.value = '0;
    s.pitch = pitch;
    s.row   = row;
    s.known = '0;
    return s;
  endfunction

  function automatic stim_step_t step_known(input int pitch, input int row,
                                            input psq_res_t known);
    stim_step_t s;
    s       = step_query(pitch, row);
    s.kind  = StepKnown;
    s.known = known;
    return s;
  endfunction

  // Random pitch set of varied density and shape
  function automatic logic [MaskW-1:0] random_pitch_set();
    logic [MaskW-1:0] m;
    logic [11:0]      octave;
    int               p;
    case ($urandom_range(0, 9))
      0: m = '1;
      1: m = '0;
      2: begin
        m = '0;
        m[$urandom_range(0, NumPitches - 1)] = 1'b1;
      end
      3, 4: m = {$urandom, $urandom, $urandom, $urandom} &
                {$urandom, $urandom, $urandom, $urandom} &
                {$urandom, $urandom, $urandom, $urandom};
      5, 6: begin
        octave = 12'($urandom);
        for (p = 0; p < NumPitches; p++) m[p] = octave[p % 12];
      end
      default: m = {$urandom, $urandom, $urandom, $urandom};
    endcase
    return m;
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegAllowedLo: allowed_set[63:0]   = value;
      RegAllowedHi: allowed_set[127:64] = value;
      RegScaleLo:   scale_set[63:0]     = value;
      RegScaleHi:   scale_set[127:64]   = value;
      default: ;
    endcase
  endtask

  // Hold the request stream and wait for every pending answer
  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Offer one request and record its answer once accepted
  task automatic send_query(input int pitch, input int row, input bit use_known,
                            input psq_res_t known);
    psq_item_t item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    item.query_pitch = 9'(pitch);
    item.query_row   = 7'(row);
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    if (use_known) pending_answers.push_back(known);
    else pending_answers.push_back(quantize_query(item.query_pitch, item.query_row));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result with the oldest answer; randomize the receiver ready
  always @(posedge clk_i) begin : result_check
    psq_res_t got;
    psq_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = psq_res_t'(m_axis_tdata[$bits(psq_res_t)-1:0]);
      if (pending_answers.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        check_field("nearest_pitch", want.nearest_pitch, got.nearest_pitch);
        check_field("nearest_found", want.nearest_found, got.nearest_found);
        check_field("pitch_row",     want.pitch_row,     got.pitch_row);
        check_field("pitch_shown",   want.pitch_shown,   got.pitch_shown);
        check_field("row_pitch",     want.row_pitch,     got.row_pitch);
        check_field("row_valid",     want.row_valid,     got.row_valid);
        check_field("row_in_scale",  want.row_in_scale,  got.row_in_scale);
        check_field("shown_count",   want.shown_count,   got.shown_count);
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : stimulus
    int               mode;
    int               set_no;
    int               n;
    int               total;
    int               pitch;
    int               row;
    logic [MaskW-1:0] new_allowed;
    logic [MaskW-1:0] new_scale;
    stim_step_t       s;

    // Chromatic set after reset: answers follow directly
    directed_steps.push_back(step_known(0, 0, res_of(0, 1, 127, 1, 127, 1, 1, 128)));
    directed_steps.push_back(step_known(127, 127, res_of(127, 1, 0, 1, 0, 1, 1, 128)));
    directed_steps.push_back(step_known(-256, 64, res_of(0, 1, 0, 0, 63, 1, 1, 128)));
    directed_steps.push_back(step_known(255, 1, res_of(127, 1, 0, 0, 126, 1, 1, 128)));
    directed_steps.push_back(step_known(-1, 0, res_of(0, 1, 0, 0, 127, 1, 1, 128)));
    directed_steps.push_back(step_known(128, 127, res_of(127, 1, 0, 0, 0, 1, 1, 128)));
    // Two pitches, 60 and 64: tie, clamping, rows past the count
    directed_steps.push_back(step_write(RegAllowedLo, 64'h1000_0000_0000_0000));
    directed_steps.push_back(step_write(RegAllowedHi, 64'h0000_0000_0000_0001));
    directed_steps.push_back(step_write(RegScaleLo, 64'h0));
    directed_steps.push_back(step_write(RegScaleHi, 64'h1));
    directed_steps.push_back(step_query(62, 0));
    directed_steps.push_back(step_query(63, 1));
    directed_steps.push_back(step_query(0, 2));
    directed_steps.push_back(step_query(127, 127));
    directed_steps.push_back(step_query(64, 0));
    directed_steps.push_back(step_query(60, 1));
    // Empty set
    directed_steps.push_back(step_write(RegAllowedLo, 64'h0));
    directed_steps.push_back(step_write(RegAllowedHi, 64'h0));
    directed_steps.push_back(step_known(5, 0, res_of(0, 0, 0, 0, 0, 0, 0, 0)));
    directed_steps.push_back(step_known(-256, 127, res_of(0, 0, 0, 0, 0, 0, 0, 0)));
    // Only the top pitch
    directed_steps.push_back(step_write(RegAllowedHi, 64'h8000_0000_0000_0000));
    directed_steps.push_back(step_query(0, 0));
    directed_steps.push_back(step_query(127, 0));
    directed_steps.push_back(step_query(-5, 1));
    // Only the bottom pitch
    directed_steps.push_back(step_write(RegAllowedLo, 64'h1));
    directed_steps.push_back(step_write(RegAllowedHi, 64'h0));
    directed_steps.push_back(step_query(255, 1));
    directed_steps.push_back(step_query(0, 0));
    // Full set again with an alternating scale
    directed_steps.push_back(step_write(RegAllowedLo, '1));
    directed_steps.push_back(step_write(RegAllowedHi, '1));
    directed_steps.push_back(step_write(RegScaleLo, 64'h5555_5555_5555_5555));
    directed_steps.push_back(step_write(RegScaleHi, 64'hAAAA_AAAA_AAAA_AAAA));
    directed_steps.push_back(step_query(77, 50));
    directed_steps.push_back(step_query(-100, 127));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.kind == StepWrite) begin
        drain_answers();
        write_reg(s.idx, s.value);
      end else begin
        send_query(s.pitch, s.row, s.kind == StepKnown, s.known);
      end
    end

    // Random pitch sets and requests under each idle pattern
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 6;
          recv_stall_pct = 77;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 6;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (set_no = 0; set_no < SetsPerMode; set_no++) begin
        drain_answers();
        new_allowed = random_pitch_set();
        new_scale   = random_pitch_set();
        write_reg(RegAllowedLo, new_allowed[63:0]);
        write_reg(RegAllowedHi, new_allowed[127:64]);
        write_reg(RegScaleLo, new_scale[63:0]);
        write_reg(RegScaleHi, new_scale[127:64]);
        total = $countones(allowed_set);
        for (n = 0; n < ItemsPerSet; n++) begin
          // Mostly pitches in range, sometimes the whole signed field
          if ($urandom_range(0, 9) < 7) pitch = $urandom_range(0, NumPitches - 1);
          else pitch = $urandom_range(0, 511);
          // Mostly rows inside the set, sometimes any row
          if (total > 0 && $urandom_range(0, 9) < 7) row = $urandom_range(0, total - 1);
          else row = $urandom_range(0, 127);
          send_query(pitch, row, 1'b0, '0);
        end
      end
    end

    drain_answers();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
